@@ rtl/uerm_pkg.sv @@
// Package for the ultrasonic echo ranger with three-point median display filter.
// Holds widths, register indexes, the measurement phase type and the pipeline beat structs.
// Depends on nothing.
package uerm_pkg;

    localparam int InWidth      = 40;
    localparam int OutWidth     = 40;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 17;
    localparam int TimeWidth    = 32;
    localparam int TickWidth    = 15;
    localparam int DistWidth    = 17;
    localparam int PeriodWidth  = 10;
    localparam int HoldWidth    = 16;
    localparam int ProdWidth    = 28;
    localparam int DistShift    = 10;

    localparam logic [3:0]           TRIG_HIGH_TICKS = 4'd10;
    localparam logic [12:0]          DIST_MULT       = 13'd4496;
    localparam logic [DistWidth-1:0] DIST_SAT        = 17'd102400;

    localparam logic [PeriodWidth-1:0] RST_SAMPLE_PERIOD = 10'd30;
    localparam logic [TickWidth-1:0]   RST_ECHO_TIMEOUT  = 15'd4000;
    localparam logic [HoldWidth-1:0]   RST_HOLD_TIMEOUT  = 16'd500;
    localparam logic [DistWidth-1:0]   RST_MIN_DIST      = 17'd384;
    localparam logic [DistWidth-1:0]   RST_MAX_DIST      = 17'd102400;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SAMPLE_PERIOD = 3'd0,
        CFG_ECHO_TIMEOUT  = 3'd1,
        CFG_HOLD_TIMEOUT  = 3'd2,
        CFG_MIN_DIST      = 3'd3,
        CFG_MAX_DIST      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic                 trig;
        logic                 done;
        logic                 echo_seen;
        logic [TickWidth-1:0] width;
        logic [TimeWidth-1:0] start_time;
    } fsm_beat_t;

    typedef struct packed {
        logic                 trig;
        logic                 done;
        logic                 raw_ok;
        logic [DistWidth-1:0] raw_value;
        logic                 in_range;
        logic [TimeWidth-1:0] start_time;
    } raw_beat_t;

endpackage

@@ rtl/ultrasonic_echo_ranger_median.sv @@
// Ultrasonic echo ranger: trigger sequencer, echo width counter, Q8 distance and median filter.
// A result beat passes through the input, sequencer, distance and filter registers in that order.
// Throughput: one beat per cycle while the output register is free; the pipeline advances only then.
// The sequencer, distance stage and filter stage are each registered.
// Reset clears the control state and loads the default configuration; the history needs none.
// Depends on uerm_pkg.
module ultrasonic_echo_ranger_median
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_axis_tdata: now_ms[31:0], echo_level[32], zero padding[39:33]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [uerm_pkg::InWidth-1:0]      s_axis_tdata,
    // m_axis_tdata: trig_level[0], sample_done[1], raw_valid[2], raw_distance[19:3],
    // display_valid[20], display_distance[37:21], zero padding[39:38]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [uerm_pkg::OutWidth-1:0]     m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uerm_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [uerm_pkg::CfgDataWidth-1:0] cfg_data
);
    import uerm_pkg::*;

    logic                   advance;

    logic [PeriodWidth-1:0] sample_period_reg;
    logic [TickWidth-1:0]   echo_timeout_reg;
    logic [HoldWidth-1:0]   hold_timeout_reg;
    logic [DistWidth-1:0]   min_dist_reg;
    logic [DistWidth-1:0]   max_dist_reg;

    logic                   s1_valid_reg;
    logic [TimeWidth-1:0]   s1_now_reg;
    logic                   s1_echo_reg;

    phase_t                 phase_reg, phase_next;
    logic [TickWidth-1:0]   phase_ticks_reg, phase_ticks_next;
    logic [TimeWidth-1:0]   last_sample_time_reg, last_sample_time_next;
    logic [TimeWidth-1:0]   sample_start_time_reg, sample_start_time_next;
    fsm_beat_t              fsm_beat;
    logic [TickWidth:0]     ticks_inc;
    logic [TickWidth:0]     timeout_ext;
    logic [TimeWidth-1:0]   since_sample;

    logic                   s2_valid_reg;
    fsm_beat_t              s2_reg;

    logic [ProdWidth-1:0]   product;
    logic [DistWidth:0]     dist_full;
    logic [DistWidth-1:0]   dist_sat;
    logic                   raw_ok_new;
    logic [DistWidth-1:0]   raw_value_new;
    logic                   raw_ok_reg, raw_ok_next;
    logic [DistWidth-1:0]   raw_value_reg, raw_value_next;
    raw_beat_t              raw_beat;

    logic                   s3_valid_reg;
    raw_beat_t              s3_reg;

    logic [DistWidth-1:0]   history_reg [3];
    logic [DistWidth-1:0]   hist_new [3];
    logic [1:0]             write_index_reg, write_index_next;
    logic [1:0]             fill_count_reg, fill_count_next;
    logic [TimeWidth-1:0]   last_valid_time_reg, last_valid_time_next;
    logic                   display_ok_reg, display_ok_next;
    logic [DistWidth-1:0]   display_value_reg, display_value_next;
    logic [DistWidth:0]     pair_sum;
    logic                   take_reading;

    logic                   m_valid_reg;
    logic [OutWidth-1:0]    m_data_reg, m_data_next;

    function automatic logic [DistWidth-1:0] med3(input logic [DistWidth-1:0] a,
                                                  input logic [DistWidth-1:0] b,
                                                  input logic [DistWidth-1:0] c);
        logic [DistWidth-1:0] lo, hi, mid_hi;
        lo     = (a < b) ? a : b;
        hi     = (a < b) ? b : a;
        mid_hi = (hi < c) ? hi : c;
        return (lo > mid_hi) ? lo : mid_hi;
    endfunction

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= RST_SAMPLE_PERIOD;
            echo_timeout_reg  <= RST_ECHO_TIMEOUT;
            hold_timeout_reg  <= RST_HOLD_TIMEOUT;
            min_dist_reg      <= RST_MIN_DIST;
            max_dist_reg      <= RST_MAX_DIST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[PeriodWidth-1:0];
                CFG_ECHO_TIMEOUT:  echo_timeout_reg  <= cfg_data[TickWidth-1:0];
                CFG_HOLD_TIMEOUT:  hold_timeout_reg  <= cfg_data[HoldWidth-1:0];
                CFG_MIN_DIST:      min_dist_reg      <= cfg_data;
                CFG_MAX_DIST:      max_dist_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_now_reg  <= s_axis_tdata[TimeWidth-1:0];
            s1_echo_reg <= s_axis_tdata[TimeWidth];
        end
    end

    // Trigger and echo sequencer: one tick per accepted beat.
    always_comb
    begin
        phase_next             = phase_reg;
        phase_ticks_next       = phase_ticks_reg;
        last_sample_time_next  = last_sample_time_reg;
        sample_start_time_next = sample_start_time_reg;
        fsm_beat               = '0;
        fsm_beat.start_time    = sample_start_time_reg;
        ticks_inc              = {1'b0, phase_ticks_reg} + 16'd1;
        timeout_ext            = {1'b0, echo_timeout_reg};
        since_sample           = s1_now_reg - last_sample_time_reg;
        unique case (phase_reg)
            PH_TRIG_LOW:
            begin
                phase_next       = PH_TRIG_HIGH;
                phase_ticks_next = '0;
            end
            PH_TRIG_HIGH:
            begin
                fsm_beat.trig = 1'b1;
                if (ticks_inc >= 16'(TRIG_HIGH_TICKS))
                begin
                    phase_next       = PH_WAIT_RISE;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc[TickWidth-1:0];
                end
            end
            PH_WAIT_RISE:
            begin
                if (s1_echo_reg)
                begin
                    phase_next       = PH_MEASURE;
                    phase_ticks_next = 15'd1;
                    if (timeout_ext <= 16'd1)
                    begin
                        fsm_beat.done      = 1'b1;
                        fsm_beat.echo_seen = 1'b1;
                        fsm_beat.width     = echo_timeout_reg;
                    end
                end
                else
                begin
                    phase_ticks_next = ticks_inc[TickWidth-1:0];
                    if (ticks_inc >= timeout_ext)
                    begin
                        fsm_beat.done = 1'b1;
                    end
                end
            end
            PH_MEASURE:
            begin
                if (s1_echo_reg)
                begin
                    phase_ticks_next = ticks_inc[TickWidth-1:0];
                    if (ticks_inc >= timeout_ext)
                    begin
                        fsm_beat.done      = 1'b1;
                        fsm_beat.echo_seen = 1'b1;
                        fsm_beat.width     = echo_timeout_reg;
                    end
                end
                else
                begin
                    fsm_beat.done      = 1'b1;
                    fsm_beat.echo_seen = 1'b1;
                    fsm_beat.width     = (phase_ticks_reg < echo_timeout_reg) ?
                                         phase_ticks_reg : echo_timeout_reg;
                end
            end
            default:
            begin
                phase_next       = PH_IDLE;
                phase_ticks_next = '0;
                if (since_sample >= TimeWidth'(sample_period_reg))
                begin
                    last_sample_time_next  = s1_now_reg;
                    sample_start_time_next = s1_now_reg;
                    phase_next             = PH_TRIG_LOW;
                    phase_ticks_next       = 15'd1;
                end
            end
        endcase
        if (fsm_beat.done)
        begin
            phase_next       = PH_IDLE;
            phase_ticks_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_IDLE;
            phase_ticks_reg       <= '0;
            last_sample_time_reg  <= '0;
            sample_start_time_reg <= '0;
            s2_valid_reg          <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                phase_reg             <= phase_next;
                phase_ticks_reg       <= phase_ticks_next;
                last_sample_time_reg  <= last_sample_time_next;
                sample_start_time_reg <= sample_start_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_reg <= fsm_beat;
        end
    end

    // Distance stage: width * 4496 >> 10, saturated, and the range check.
    always_comb
    begin
        product       = ProdWidth'(s2_reg.width) * ProdWidth'(DIST_MULT);
        dist_full     = product[ProdWidth-1:DistShift];
        dist_sat      = (dist_full > (DistWidth+1)'(DIST_SAT)) ? DIST_SAT
                                                              : dist_full[DistWidth-1:0];
        raw_ok_new    = s2_reg.echo_seen && (s2_reg.width != '0);
        raw_value_new = raw_ok_new ? dist_sat : '0;
        raw_ok_next   = s2_reg.done ? raw_ok_new : raw_ok_reg;
        raw_value_next = s2_reg.done ? raw_value_new : raw_value_reg;
        raw_beat.trig       = s2_reg.trig;
        raw_beat.done       = s2_reg.done;
        raw_beat.raw_ok     = raw_ok_next;
        raw_beat.raw_value  = raw_value_next;
        raw_beat.in_range   = raw_ok_new && (raw_value_new > min_dist_reg)
                                         && (raw_value_new < max_dist_reg);
        raw_beat.start_time = s2_reg.start_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_ok_reg    <= 1'b0;
            raw_value_reg <= '0;
            s3_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                raw_ok_reg    <= raw_ok_next;
                raw_value_reg <= raw_value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_reg <= raw_beat;
        end
    end

    // Filter stage: history update, display value and hold timeout.
    always_comb
    begin
        take_reading         = s3_reg.done && s3_reg.in_range;
        write_index_next     = write_index_reg;
        fill_count_next      = fill_count_reg;
        last_valid_time_next = last_valid_time_reg;
        display_ok_next      = display_ok_reg;
        display_value_next   = display_value_reg;
        for (int k = 0; k < 3; k++)
        begin
            hist_new[k] = (write_index_reg == 2'(k)) ? s3_reg.raw_value : history_reg[k];
        end
        pair_sum = {1'b0, hist_new[0]} + {1'b0, hist_new[1]};
        if (take_reading)
        begin
            last_valid_time_next = s3_reg.start_time;
            write_index_next     = (write_index_reg == 2'd2) ? 2'd0 : write_index_reg + 2'd1;
            fill_count_next      = (fill_count_reg == 2'd3) ? 2'd3 : fill_count_reg + 2'd1;
            display_ok_next      = 1'b1;
            priority if (fill_count_next == 2'd1)
            begin
                display_value_next = hist_new[0];
            end
            else if (fill_count_next == 2'd2)
            begin
                display_value_next = pair_sum[DistWidth:1];
            end
            else
            begin
                display_value_next = med3(hist_new[0], hist_new[1], hist_new[2]);
            end
        end
        else if (s3_reg.done &&
                 ((s3_reg.start_time - last_valid_time_reg) > TimeWidth'(hold_timeout_reg)))
        begin
            display_ok_next    = 1'b0;
            display_value_next = '0;
        end
        m_data_next = {2'b00, display_value_next, display_ok_next, s3_reg.raw_value,
                       s3_reg.raw_ok, s3_reg.done, s3_reg.trig};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg     <= '0;
            fill_count_reg      <= '0;
            last_valid_time_reg <= '0;
            display_ok_reg      <= 1'b0;
            display_value_reg   <= '0;
            m_valid_reg         <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                write_index_reg     <= write_index_next;
                fill_count_reg      <= fill_count_next;
                last_valid_time_reg <= last_valid_time_next;
                display_ok_reg      <= display_ok_next;
                display_value_reg   <= display_value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_data_reg <= m_data_next;
            if (s3_valid_reg && take_reading)
            begin
                history_reg[write_index_reg] <= s3_reg.raw_value;
            end
        end
    end

    a_display_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        !display_ok_reg |-> (display_value_reg == '0))
        else $error("display value is not zero while the display is invalid");

    a_trig_high_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TRIG_HIGH) |-> (phase_ticks_reg < 15'(TRIG_HIGH_TICKS)))
        else $error("trigger high count ran past its length");

    a_history_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (write_index_reg != 2'd3) && ((fill_count_reg == 2'd3) ||
                                      (write_index_reg == fill_count_reg)))
        else $error("history write index and fill count disagree");

    a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[1]))
        else $error("a result beat shows trigger and sample done together");

endmodule

@@ tb/sv/ultrasonic_echo_ranger_median_tb.sv @@
// Self-checking testbench for the ultrasonic echo ranger with median display filter.
// Drives echo waveforms tick by tick, predicts every output beat and checks them in order.
// Depends on uerm_pkg and the ultrasonic_echo_ranger_median RTL.
module ultrasonic_echo_ranger_median_tb;
    import uerm_pkg::*;

    localparam int unsigned     WatchdogLimit = 2000;
    localparam int unsigned     RandomTicks   = 300;
    localparam int unsigned     QuietTicks    = 100;
    localparam int unsigned     ReportLimit   = 200;
    localparam int unsigned     TrigHighTicks = 10;
    localparam logic [12:0]     Q8PerTick     = 13'd4496;
    localparam logic [16:0]     FullScaleQ8   = 17'd102400;
    localparam logic [16:0]     MaxField17    = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]           pad;
        logic [DistWidth-1:0] display_distance;
        logic                 display_valid;
        logic [DistWidth-1:0] raw_distance;
        logic                 raw_valid;
        logic                 sample_done;
        logic                 trig_level;
    } ranger_out_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [InWidth-1:0]      s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OutWidth-1:0]     m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    // Predicted state of the ranger.
    logic [PeriodWidth-1:0] period_ms;
    logic [TickWidth-1:0]   echo_limit;
    logic [HoldWidth-1:0]   hold_ms;
    logic [DistWidth-1:0]   min_q8;
    logic [DistWidth-1:0]   max_q8;
    phase_t                 ph;
    logic [TickWidth-1:0]   ph_ticks;
    logic [TimeWidth-1:0]   last_start_ms;
    logic [TimeWidth-1:0]   start_ms;
    logic [TimeWidth-1:0]   last_valid_ms;
    logic [DistWidth-1:0]   hist [3];
    logic [1:0]             hist_wr;
    logic [1:0]             hist_fill;
    logic                   raw_ok;
    logic [DistWidth-1:0]   raw_q8;
    logic                   shown_ok;
    logic [DistWidth-1:0]   shown_q8;

    ranger_out_t predicted_ticks [$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned ticks_sent   = 0;
    bit          idling       = 1'b0;

    ultrasonic_echo_ranger_median i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DistWidth-1:0] q8_of_width(input logic [TickWidth-1:0] w);
        logic [27:0] prod;
        logic [17:0] q;
        prod = 28'(w) * 28'(Q8PerTick);
        q    = prod[27:10];
        return (q > 18'(FullScaleQ8)) ? FullScaleQ8 : q[16:0];
    endfunction

    function automatic void close_reading(input logic seen, input logic [TickWidth-1:0] w);
        logic [DistWidth-1:0] d;
        logic [DistWidth-1:0] a;
        logic [DistWidth-1:0] b;
        logic [DistWidth-1:0] c;
        logic [17:0]          pair;
        d      = q8_of_width(w);
        raw_ok = seen && (w != '0);
        raw_q8 = raw_ok ? d : '0;
        if (raw_ok && raw_q8 > min_q8 && raw_q8 < max_q8)
        begin
            last_valid_ms = start_ms;
            hist[hist_wr] = raw_q8;
            hist_wr       = (hist_wr == 2'd2) ? 2'd0 : hist_wr + 2'd1;
            if (hist_fill != 2'd3)
                hist_fill = hist_fill + 2'd1;
            a = hist[0];
            b = hist[1];
            c = hist[2];
            if (hist_fill == 2'd1)
                shown_q8 = a;
            else if (hist_fill == 2'd2)
            begin
                pair     = 18'(a) + 18'(b);
                shown_q8 = pair[17:1];
            end
            else if (a > b)
                shown_q8 = (b > c) ? b : ((a > c) ? c : a);
            else
                shown_q8 = (a > c) ? a : ((b > c) ? c : b);
            shown_ok = 1'b1;
        end
        else if (start_ms - last_valid_ms > 32'(hold_ms))
        begin
            shown_ok = 1'b0;
            shown_q8 = '0;
        end
        ph       = PH_IDLE;
        ph_ticks = '0;
    endfunction

    function automatic ranger_out_t advance_ranger(input logic [TimeWidth-1:0] now,
                                                   input logic echo);
        ranger_out_t r;
        r = '0;
        case (ph)
            PH_TRIG_LOW:
            begin
                ph       = PH_TRIG_HIGH;
                ph_ticks = '0;
            end
            PH_TRIG_HIGH:
            begin
                r.trig_level = 1'b1;
                ph_ticks     = ph_ticks + 1'b1;
                if (ph_ticks >= 15'(TrigHighTicks))
                begin
                    ph       = PH_WAIT_RISE;
                    ph_ticks = '0;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo)
                begin
                    ph       = PH_MEASURE;
                    ph_ticks = 15'd1;
                    if (ph_ticks >= echo_limit)
                    begin
                        close_reading(1'b1, echo_limit);
                        r.sample_done = 1'b1;
                    end
                end
                else
                begin
                    ph_ticks = ph_ticks + 1'b1;
                    if (ph_ticks >= echo_limit)
                    begin
                        close_reading(1'b0, '0);
                        r.sample_done = 1'b1;
                    end
                end
            end
            PH_MEASURE:
            begin
                if (echo)
                begin
                    ph_ticks = ph_ticks + 1'b1;
                    if (ph_ticks >= echo_limit)
                    begin
                        close_reading(1'b1, echo_limit);
                        r.sample_done = 1'b1;
                    end
                end
                else
                begin
                    close_reading(1'b1, (ph_ticks < echo_limit) ? ph_ticks : echo_limit);
                    r.sample_done = 1'b1;
                end
            end
            default:
            begin
                ph       = PH_IDLE;
                ph_ticks = '0;
                if (now - last_start_ms >= 32'(period_ms))
                begin
                    last_start_ms = now;
                    start_ms      = now;
                    ph            = PH_TRIG_LOW;
                    ph_ticks      = 15'd1;
                end
            end
        endcase
        r.raw_valid        = raw_ok;
        r.raw_distance     = raw_q8;
        r.display_valid    = shown_ok;
        r.display_distance = shown_q8;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [DistWidth-1:0] want,
                                        input logic [DistWidth-1:0] got);
        if (got !== want)
        begin
            if (mismatches < ReportLimit)
                $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_tick(input logic [TimeWidth-1:0] now, input logic echo);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, echo, now};
        do @(posedge clk); while (!s_axis_tready);
        predicted_ticks.push_back(advance_ranger(now, echo));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (predicted_ticks.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SAMPLE_PERIOD: period_ms  = value[PeriodWidth-1:0];
            CFG_ECHO_TIMEOUT:  echo_limit = value[TickWidth-1:0];
            CFG_HOLD_TIMEOUT:  hold_ms    = value[HoldWidth-1:0];
            CFG_MIN_DIST:      min_q8     = value[DistWidth-1:0];
            CFG_MAX_DIST:      max_q8     = value[DistWidth-1:0];
            default:           ;
        endcase
    endtask

    task automatic load_config(input logic [PeriodWidth-1:0] period,
                               input logic [TickWidth-1:0] limit,
                               input logic [HoldWidth-1:0] hold,
                               input logic [DistWidth-1:0] lo,
                               input logic [DistWidth-1:0] hi);
        wait_drained();
        write_reg(CFG_SAMPLE_PERIOD, 17'(period));
        write_reg(CFG_ECHO_TIMEOUT, 17'(limit));
        write_reg(CFG_HOLD_TIMEOUT, 17'(hold));
        write_reg(CFG_MIN_DIST, lo);
        write_reg(CFG_MAX_DIST, hi);
        cfg_valid <= 1'b0;
    endtask

    // Waits out the period, lets the trigger run, then shapes the echo: low for rise
    // ticks after the trigger, high for high ticks, low until the reading closes (random if noisy).
    task automatic take_sample(input int unsigned rise, input int unsigned high,
                               input logic [TimeWidth-1:0] extra, input bit noisy);
        int unsigned          n;
        logic                 echo;
        logic [TimeWidth-1:0] due;
        if (period_ms != '0 && ph == PH_IDLE)
            send_tick(last_start_ms + 32'(period_ms) - 32'd1, 1'($urandom_range(0, 1)));
        due = last_start_ms + 32'(period_ms) + extra;
        while (ph == PH_IDLE)
            send_tick(due, 1'($urandom_range(0, 1)));
        n = 0;
        while (ph != PH_IDLE)
        begin
            if (ph == PH_WAIT_RISE || ph == PH_MEASURE)
            begin
                echo = noisy ? 1'($urandom_range(0, 1)) : (n >= rise && n < rise + high);
                n++;
            end
            else
                echo = 1'($urandom_range(0, 1));
            send_tick($urandom(), echo);
        end
    endtask

    task automatic check_power_on_defaults();
        idling = 1'b1;
        send_tick(32'd0, 1'b1);
        take_sample(3, 100, 32'd0, 1'b0);
        take_sample(0, 87, 32'd0, 1'b0);
    endtask

    task automatic check_echo_limits();
        load_config(10'd0, 15'd0, 16'd500, 17'd0, MaxField17);
        take_sample(0, 0, 32'd0, 1'b0);
        take_sample(0, 5, 32'd0, 1'b0);
        load_config(10'd0, 15'd1, 16'd500, 17'd0, MaxField17);
        take_sample(0, 1, 32'd0, 1'b0);
        take_sample(2, 3, 32'd0, 1'b0);
        load_config(10'd1, 15'd6, 16'd500, 17'd0, MaxField17);
        take_sample(5, 3, 32'd0, 1'b0);
        take_sample(6, 3, 32'd0, 1'b0);
        take_sample(0, 20, 32'd0, 1'b0);
        take_sample(0, 5, 32'd0, 1'b0);
    endtask

    task automatic check_range_bounds();
        logic [DistWidth-1:0] d;
        d = q8_of_width(15'd12);
        load_config(10'd1, 15'd20, 16'd65535, d, MaxField17);
        take_sample(0, 12, 32'd0, 1'b0);
        load_config(10'd1, 15'd20, 16'd65535, d - 17'd1, d + 17'd1);
        take_sample(1, 12, 32'd0, 1'b0);
        load_config(10'd1, 15'd20, 16'd65535, 17'd0, d);
        take_sample(2, 12, 32'd0, 1'b0);
        load_config(10'd1, 15'd20, 16'd65535, d + 17'd61, d - 17'd39);
        take_sample(0, 12, 32'd0, 1'b0);
        load_config(10'd1, 15'd20, 16'd65535, d, d);
        take_sample(0, 12, 32'd0, 1'b0);
    endtask

    task automatic check_median_history();
        load_config(10'd1, 15'd100, 16'd1000, 17'd0, MaxField17);
        foreach (hist[i])
        begin
            take_sample(1, 6, 32'd0, 1'b0);
            take_sample(0, 2, 32'd1, 1'b0);
            take_sample(2, 10, 32'd0, 1'b0);
            take_sample(0, 3 + i, 32'd0, 1'b0);
        end
        take_sample(0, 11, 32'd0, 1'b0);
        take_sample(0, 1, 32'd0, 1'b0);
    endtask

    task automatic check_hold_and_wrap();
        load_config(10'd0, 15'd8, 16'd0, 17'd0, MaxField17);
        take_sample(0, 5, 32'd0, 1'b0);
        take_sample(10, 0, 32'd0, 1'b0);
        take_sample(10, 0, 32'd1, 1'b0);
        load_config(10'd0, 15'd8, 16'd65535, 17'd0, MaxField17);
        take_sample(0, 5, 32'd0, 1'b0);
        take_sample(10, 0, 32'd65535, 1'b0);
        take_sample(10, 0, 32'd1, 1'b0);
        load_config(10'd1023, 15'd8, 16'd2000, 17'd0, MaxField17);
        take_sample(0, 5, 32'hFFFF_FFFF - last_start_ms - 32'd1023, 1'b0);
        take_sample(10, 0, 32'd0, 1'b0);
        take_sample(10, 0, 32'd1000, 1'b0);
    endtask

    task automatic check_full_scale();
        load_config(10'd1, 15'h7FFF, 16'd100, 17'd0, MaxField17);
        take_sample(0, 40, 32'd0, 1'b0);
        take_sample(1, 2, 32'd0, 1'b0);
    endtask

    task automatic run_random_ranging();
        int unsigned            start_count;
        int unsigned            samples;
        int unsigned            rise;
        int unsigned            high;
        int unsigned            pick;
        logic [TimeWidth-1:0]   extra;
        logic [PeriodWidth-1:0] period;
        logic [TickWidth-1:0]   limit;
        logic [HoldWidth-1:0]   hold;
        logic [DistWidth-1:0]   lo;
        logic [DistWidth-1:0]   hi;
        bit                     noisy;
        start_count = ticks_sent;
        samples     = 0;
        while (ticks_sent - start_count < RandomTicks)
        begin
            idling = (ticks_sent - start_count) < RandomTicks - QuietTicks;
            if (samples % 5 == 0)
            begin
                period = ($urandom_range(0, 5) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 3));
                limit  = ($urandom_range(0, 5) == 0) ? 15'($urandom()) : 15'($urandom_range(0, 80));
                hold   = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 30));
                lo     = ($urandom_range(0, 5) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 200));
                hi     = ($urandom_range(0, 5) == 0) ? 17'($urandom()) : 17'($urandom_range(100, 400));
                load_config(period, limit, hold, lo, hi);
            end
            noisy = ($urandom_range(0, 7) == 0);
            rise  = $urandom_range(0, 9);
            high  = $urandom_range(1, 70);
            if (echo_limit <= 15'd100 && $urandom_range(0, 6) == 0)
                rise = echo_limit + $urandom_range(0, 2);
            pick  = $urandom_range(0, 19);
            if (pick == 0)
                extra = $urandom() & 32'h7FFF_FFFF;
            else if (pick < 5)
                extra = $urandom_range(0, 60);
            else
                extra = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_tick($urandom(), 1'($urandom_range(0, 1)));
            take_sample(rise, high, extra, noisy);
            samples++;
        end
        idling = 1'b0;
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ranger_out_t want;
        ranger_out_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = ranger_out_t'(m_axis_tdata);
            if (predicted_ticks.size() == 0)
            begin
                if (mismatches < ReportLimit)
                    $error("result beat with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = predicted_ticks.pop_front();
                check_field("trig_level", 17'(want.trig_level), 17'(got.trig_level));
                check_field("sample_done", 17'(want.sample_done), 17'(got.sample_done));
                check_field("raw_valid", 17'(want.raw_valid), 17'(got.raw_valid));
                check_field("raw_distance", want.raw_distance, got.raw_distance);
                check_field("display_valid", 17'(want.display_valid), 17'(got.display_valid));
                check_field("display_distance", want.display_distance, got.display_distance);
                check_field("padding", 17'(want.pad), 17'(got.pad));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WatchdogLimit)
        begin
            $display("ultrasonic_echo_ranger_median regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        period_ms     = 10'd30;
        echo_limit    = 15'd4000;
        hold_ms       = 16'd500;
        min_q8        = 17'd384;
        max_q8        = 17'd102400;
        ph            = PH_IDLE;
        ph_ticks      = '0;
        last_start_ms = '0;
        start_ms      = '0;
        last_valid_ms = '0;
        hist[0]       = '0;
        hist[1]       = '0;
        hist[2]       = '0;
        hist_wr       = '0;
        hist_fill     = '0;
        raw_ok        = 1'b0;
        raw_q8        = '0;
        shown_ok      = 1'b0;
        shown_q8      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        check_power_on_defaults();
        check_echo_limits();
        check_range_bounds();
        check_median_history();
        check_hold_and_wrap();
        check_full_scale();
        run_random_ranging();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ultrasonic_echo_ranger_median regression: pass");
        else
            $display("ultrasonic_echo_ranger_median regression: fail");
        $finish;
    end

endmodule
